@@ src/tms_pkg.sv @@
// ============================================================================
// tms_pkg: shared types and constants of the trackball motion shaper
// Beat layouts, configuration register indexes, sequencer states and the
// fixed widths of the report fields.
// ============================================================================
package tms_pkg;

    localparam int FIELD_W       = 8;
    localparam int MAG_W         = 7;
    localparam int SUM_W         = 9;
    localparam int CUR_PROD_W    = 11;
    localparam int STEP_W        = 11;
    localparam int ACC_INT_BITS  = 10;
    localparam int GAIN_W        = 4;
    localparam int FDIV_W        = 4;
    localparam int SDIV_W        = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 6;
    localparam int LIMIT         = 127;
    localparam int SQRT_HALF_Q24 = 11863283;

    localparam logic [MAG_W-1:0]  MAG_MAX         = 7'd127;
    localparam logic [GAIN_W-1:0] GAIN_RESET      = 4'd3;
    localparam logic [FDIV_W-1:0] FINE_DIV_RESET  = 4'd3;
    localparam logic [SDIV_W-1:0] SCROLL_DIV_RESET = 6'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURSOR_GAIN    = 2'd0,
        CFG_FINE_DIVISOR   = 2'd1,
        CFG_SCROLL_DIVISOR = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_PREP,
        ST_DIV,
        ST_POST,
        ST_STEP
    } tms_state_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] delta_x;
        logic signed [FIELD_W-1:0] delta_y;
        logic signed [FIELD_W-1:0] wheel_h_in;
        logic signed [FIELD_W-1:0] wheel_v_in;
        logic                      scroll_mode;
        logic                      fine_mode;
    } in_beat_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] cursor_x;
        logic signed [FIELD_W-1:0] cursor_y;
        logic signed [FIELD_W-1:0] wheel_h_out;
        logic signed [FIELD_W-1:0] wheel_v_out;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic shift;
    } div_ctl_t;

endpackage

@@ src/trackball_motion_shaper.sv @@
// ============================================================================
// trackball_motion_shaper: rotate, scroll-accumulate or gain-scale motion
// One motion report in, one shaped report out. Motion is rotated by minus
// 45 degrees, then either turned into wheel steps through fractional
// accumulators or scaled into cursor motion.
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid/s_ready    in_beat_t
//   m_*          out  m_valid/m_ready    out_beat_t
//   cfg_*        in   cfg_we             cfg_index, cfg_wdata
//
// After accept an item passes through ST_ROT, ST_PREP, ST_DIV, ST_POST and
// ST_STEP; its result registers in ST_STEP, and the next item is accepted
// only once back in ST_IDLE. The bit-serial divider lanes work in ST_DIV:
// one quotient bit a cycle over ACC_FRAC_BITS+7 bits.
// Reset clears both accumulators and restores the register defaults.
// A result not yet taken holds the item in ST_STEP; no next item is accepted.
// ============================================================================
module trackball_motion_shaper #(
    parameter int ACC_FRAC_BITS  = 16,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tms_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tms_pkg::out_beat_t                m_data,
    input  logic                              cfg_we,
    input  logic [tms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tms_pkg::*;

    localparam int ACC_W      = ACC_FRAC_BITS + ACC_INT_BITS;
    localparam int DVD_W      = ACC_FRAC_BITS + MAG_W;
    localparam int CNT_W      = $clog2(DVD_W);
    localparam int COEF_W     = COEF_FRAC_BITS;
    localparam int ROT_PROD_W = SUM_W + COEF_W;
    localparam logic [COEF_W-1:0] COEF = COEF_W'(
        (SQRT_HALF_Q24 + (1 << (23 - COEF_FRAC_BITS))) >> (24 - COEF_FRAC_BITS));
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    tms_state_t state_reg, state_next;

    logic [GAIN_W-1:0] gain_reg;
    logic [FDIV_W-1:0] fdiv_reg;
    logic [SDIV_W-1:0] sdiv_reg;

    in_beat_t          in_reg;
    logic [MAG_W-1:0]  rmag_reg [2];
    logic              rneg_reg [2];
    logic [CNT_W-1:0]  cnt_reg;
    logic signed [ACC_W-1:0] acc_reg [2];
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    div_ctl_t          div_ctl;
    logic              out_free;
    logic              post_en;
    logic              commit;

    logic signed [SUM_W-1:0]      rot_sum [2];
    logic [SUM_W-1:0]             rot_abs [2];
    logic [ROT_PROD_W-1:0]        rot_prod [2];
    logic [SUM_W-1:0]             rot_q [2];
    logic [MAG_W-1:0]             rot_mag [2];

    logic [SDIV_W-1:0]            sdiv_eff;
    logic [SDIV_W-1:0]            fdiv_eff;
    logic [SDIV_W-1:0]            div_divisor;
    logic                         keep_x;
    logic [MAG_W-1:0]             smag [2];
    logic [CUR_PROD_W-1:0]        cur_prod [2];
    logic [DVD_W-1:0]             div_dividend [2];
    logic [DVD_W-1:0]             quo [2];

    logic signed [ACC_W:0]        q_signed [2];
    logic signed [ACC_W:0]        acc_sum [2];
    logic signed [ACC_W-1:0]      acc_post [2];

    logic signed [ACC_INT_BITS-1:0] ip [2];
    logic signed [STEP_W-1:0]     stp [2];
    logic signed [FIELD_W-1:0]    wheel_raw [2];
    logic signed [FIELD_W-1:0]    wheel_in [2];
    logic signed [STEP_W-1:0]     wheel_sum [2];
    logic signed [FIELD_W-1:0]    wheel_out [2];
    logic signed [STEP_W-1:0]     used [2];
    logic signed [STEP_W-1:0]     ip_new [2];
    logic signed [ACC_W-1:0]      acc_step [2];
    logic [MAG_W-1:0]             cmag [2];
    logic signed [FIELD_W-1:0]    cur_val [2];
    out_beat_t                    result;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_ROT;
            ST_ROT:  state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_POST;
            ST_POST: state_next = ST_STEP;
            ST_STEP: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        out_free      = !m_valid_reg || m_ready;
        s_ready       = (state_reg == ST_IDLE);
        div_ctl.load  = (state_reg == ST_PREP);
        div_ctl.shift = (state_reg == ST_DIV);
        post_en       = (state_reg == ST_POST) && in_reg.scroll_mode;
        commit        = (state_reg == ST_STEP) && out_free;
    end

    // rotation by minus 45 degrees, truncated toward zero
    always_comb begin
        rot_sum[0] = SUM_W'(in_reg.delta_x) + SUM_W'(in_reg.delta_y);
        rot_sum[1] = SUM_W'(in_reg.delta_y) - SUM_W'(in_reg.delta_x);
        for (int i = 0; i < 2; i++) begin
            rot_abs[i]  = rot_sum[i][SUM_W-1] ? SUM_W'(-rot_sum[i]) : SUM_W'(rot_sum[i]);
            rot_prod[i] = ROT_PROD_W'(rot_abs[i]) * ROT_PROD_W'(COEF);
            rot_q[i]    = rot_prod[i][ROT_PROD_W-1:COEF_W];
            rot_mag[i]  = (rot_q[i] > SUM_W'(MAG_MAX)) ? MAG_MAX : rot_q[i][MAG_W-1:0];
        end
    end

    // divider operands
    always_comb begin
        sdiv_eff = (sdiv_reg == '0) ? SDIV_W'(1) : sdiv_reg;
        fdiv_eff = (fdiv_reg == '0) ? SDIV_W'(1) : SDIV_W'(fdiv_reg);
        if (in_reg.scroll_mode) begin
            div_divisor = sdiv_eff;
        end else if (in_reg.fine_mode) begin
            div_divisor = fdiv_eff;
        end else begin
            div_divisor = SDIV_W'(1);
        end
        keep_x  = rmag_reg[0] > rmag_reg[1];
        smag[0] = keep_x ? rmag_reg[0] : '0;
        smag[1] = keep_x ? '0 : rmag_reg[1];
        for (int i = 0; i < 2; i++) begin
            cur_prod[i] = CUR_PROD_W'(rmag_reg[i]) * CUR_PROD_W'(gain_reg);
            div_dividend[i] = in_reg.scroll_mode ? {smag[i], {ACC_FRAC_BITS{1'b0}}}
                                                 : DVD_W'(cur_prod[i]);
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        tms_serial_div #(
            .DVD_W(DVD_W)
        ) u_div (
            .aclk     (aclk),
            .ctl      (div_ctl),
            .dividend (div_dividend[g]),
            .divisor  (div_divisor),
            .quotient (quo[g])
        );
    end

    // accumulate and take whole wheel steps
    always_comb begin
        wheel_raw[0] = in_reg.wheel_h_in;
        wheel_raw[1] = in_reg.wheel_v_in;
        for (int i = 0; i < 2; i++) begin
            q_signed[i] = rneg_reg[i] ? -$signed({1'b0, (ACC_W)'(quo[i])})
                                      : $signed({1'b0, (ACC_W)'(quo[i])});
            acc_sum[i]  = (ACC_W+1)'(acc_reg[i]) + q_signed[i];
            if (acc_sum[i] > (ACC_W+1)'(ACC_MAX)) begin
                acc_post[i] = ACC_MAX;
            end else if (acc_sum[i] < (ACC_W+1)'(ACC_MIN)) begin
                acc_post[i] = ACC_MIN;
            end else begin
                acc_post[i] = acc_sum[i][ACC_W-1:0];
            end

            ip[i]  = acc_reg[i][ACC_W-1:ACC_FRAC_BITS];
            stp[i] = STEP_W'(ip[i])
                   + ((acc_reg[i][ACC_W-1] && (|acc_reg[i][ACC_FRAC_BITS-1:0]))
                      ? STEP_W'(1) : STEP_W'(0));
            wheel_in[i]  = (wheel_raw[i] < -LIMIT) ? FIELD_W'(-LIMIT) : wheel_raw[i];
            wheel_sum[i] = STEP_W'(wheel_in[i]) + stp[i];
            if (wheel_sum[i] > STEP_W'(LIMIT)) begin
                wheel_out[i] = FIELD_W'(LIMIT);
            end else if (wheel_sum[i] < STEP_W'(-LIMIT)) begin
                wheel_out[i] = FIELD_W'(-LIMIT);
            end else begin
                wheel_out[i] = wheel_sum[i][FIELD_W-1:0];
            end
            used[i]     = STEP_W'(wheel_out[i]) - STEP_W'(wheel_in[i]);
            ip_new[i]   = STEP_W'(ip[i]) - used[i];
            acc_step[i] = {ip_new[i][ACC_INT_BITS-1:0], acc_reg[i][ACC_FRAC_BITS-1:0]};

            cmag[i]    = (|quo[i][DVD_W-1:MAG_W]) ? MAG_MAX : quo[i][MAG_W-1:0];
            cur_val[i] = rneg_reg[i] ? -$signed({1'b0, cmag[i]}) : $signed({1'b0, cmag[i]});
        end

        if (in_reg.scroll_mode) begin
            result.cursor_x    = '0;
            result.cursor_y    = '0;
            result.wheel_h_out = wheel_out[0];
            result.wheel_v_out = wheel_out[1];
        end else begin
            result.cursor_x    = cur_val[0];
            result.cursor_y    = cur_val[1];
            result.wheel_h_out = wheel_in[0];
            result.wheel_v_out = wheel_in[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= GAIN_RESET;
            fdiv_reg    <= FINE_DIV_RESET;
            sdiv_reg    <= SCROLL_DIV_RESET;
            cnt_reg     <= '0;
            acc_reg[0]  <= '0;
            acc_reg[1]  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CURSOR_GAIN:    gain_reg <= cfg_wdata[GAIN_W-1:0];
                    CFG_FINE_DIVISOR:   fdiv_reg <= cfg_wdata[FDIV_W-1:0];
                    CFG_SCROLL_DIVISOR: sdiv_reg <= cfg_wdata[SDIV_W-1:0];
                    default: ;
                endcase
            end
            if (div_ctl.load) begin
                cnt_reg <= CNT_W'(DVD_W - 1);
            end else if (div_ctl.shift) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            for (int i = 0; i < 2; i++) begin
                if (post_en) begin
                    acc_reg[i] <= acc_post[i];
                end else if (commit && in_reg.scroll_mode) begin
                    acc_reg[i] <= acc_step[i];
                end
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_ROT) begin
            for (int i = 0; i < 2; i++) begin
                rmag_reg[i] <= rot_mag[i];
                rneg_reg[i] <= rot_sum[i][SUM_W-1];
            end
        end
        if (commit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == ST_POST || state_reg == ST_STEP)
        |=> $stable(acc_reg[0]) && $stable(acc_reg[1]))
        else $error("accumulator changed outside the update steps");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_STEP))
        else $error("result raised without a finished item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.wheel_h_out != -8'sd128)
                     && (m_data_reg.wheel_v_out != -8'sd128)
                     && (m_data_reg.cursor_x != -8'sd128)
                     && (m_data_reg.cursor_y != -8'sd128))
        else $error("result field outside plus or minus 127");

endmodule

@@ src/tms_serial_div.sv @@
// ============================================================================
// tms_serial_div: bit-serial restoring divider lane
// Unsigned dividend over a narrow divisor, one quotient bit per cycle while
// ctl.shift is held, quotient bits shifted into the dividend register.
// ============================================================================
module tms_serial_div #(
    parameter int DVD_W = 23
) (
    input  logic                         aclk,
    input  tms_pkg::div_ctl_t            ctl,
    input  logic [DVD_W-1:0]             dividend,
    input  logic [tms_pkg::SDIV_W-1:0]   divisor,
    output logic [DVD_W-1:0]             quotient
);
    import tms_pkg::*;

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [SDIV_W-1:0] rem_reg, rem_next;
    logic [SDIV_W-1:0] dsr_reg, dsr_next;
    logic [SDIV_W:0]   trial;
    logic [SDIV_W:0]   diff;
    logic              fits;

    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (ctl.load) begin
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (ctl.shift) begin
            rem_next = fits ? diff[SDIV_W-1:0] : trial[SDIV_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = dvd_reg;

endmodule
